/* rtl/mass_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Multilevel aging slot scheduler package
// Shared queue tag codes, controller states, register indexes and defaults.
// ---------------------------------------------------------------------------
package mass_pkg;

   // Default sizing of the job table and of the slot counts.
   localparam int DEF_MAX_JOBS         = 64;
   localparam int DEF_SLOT_COUNT_WIDTH = 16;

   // Register reset values.
   localparam logic [15:0] ALLOWANCE_RESET = 16'd8;
   localparam logic [15:0] THRESHOLD_RESET = 16'd100;

   // Register indexes on the write port.
   localparam logic [0:0] CSR_TIME_ALLOWANCE = 1'b0;
   localparam logic [0:0] CSR_AGE_THRESHOLD  = 1'b1;

   // Queue membership of one job entry.
   typedef enum logic [2:0] {
      TAG_NONE    = 3'd0,
      TAG_PNEW    = 3'd1,
      TAG_PPLAYED = 3'd2,
      TAG_RNEW    = 3'd3,
      TAG_RPLAYED = 3'd4,
      TAG_LONG    = 3'd5,
      TAG_RUN_P   = 3'd6,
      TAG_RUN_R   = 3'd7
   } tag_type;

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ARR,
      ST_RET,
      ST_SCAN,
      ST_PICK,
      ST_DISP
   } state_type;

endpackage

/* rtl/multilevel_aging_slot_scheduler.sv */
`timescale 1ns / 1ps
// Arrival item: entry read at acceptance, write back after; no result.
// Tick item: one sweep over the
// job RAM at one entry per cycle, plus an optional retire and dispatch access.
// The tick result is strobed on rsp_valid in the first cycle that busy is low again.
// Reset clears all control state and marks every job entry unused; no clearing pass.
// ---------------------------------------------------------------------------
// Multilevel aging slot scheduler
// Job queues kept as tags in one job RAM; a tick retires an ended run, sweeps
// the table to age regular jobs and find the best job; dispatches when idle.
// ---------------------------------------------------------------------------
module multilevel_aging_slot_scheduler
   import mass_pkg::*;
#(
   parameter int MAX_JOBS         = DEF_MAX_JOBS,
   parameter int SLOT_COUNT_WIDTH = DEF_SLOT_COUNT_WIDTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_func,
   input  logic [5:0]  req_customer_id,
   input  logic        req_regular_class,
   input  logic [15:0] req_slots_requested,
   input  logic        csr_wr_en,
   input  logic [0:0]  csr_index,
   input  logic [15:0] csr_wdata,
   output logic        rsp_valid,
   output logic [31:0] rsp_time_slot,
   output logic        rsp_machine_busy,
   output logic [5:0]  rsp_active_customer,
   output logic        rsp_all_queues_empty
);

   localparam int IW = $clog2(MAX_JOBS);
   localparam int CW = IW + 1;
   localparam int SW = SLOT_COUNT_WIDTH;

   typedef struct packed {
      tag_type       tag;
      logic [15:0]   stamp;
      logic [15:0]   age;
      logic [SW-1:0] rem;
   } entry_type;

   localparam int EW = $bits(entry_type);

   // Registers.
   state_type     state_ff, state_in;
   logic [15:0]   allow_ff, allow_in;
   logic [15:0]   thresh_ff, thresh_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [IW-1:0] rd_addr_ff, rd_addr_in;
   logic          arr_regular_ff, arr_regular_in;
   logic [SW-1:0] arr_slots_ff, arr_slots_in;
   logic          run_regular_ff, run_regular_in;
   logic [31:0]   slot_ff, slot_in;
   logic          busy_flag_ff, busy_flag_in;
   logic [IW-1:0] run_id_ff, run_id_in;
   logic [31:0]   preempt_ff, preempt_in;
   logic [31:0]   run_start_ff, run_start_in;
   logic [15:0]   arr_cnt_ff, arr_cnt_in;
   logic [MAX_JOBS-1:0] valid_ff, valid_in;
   logic          any_ff, any_in;
   logic          long_found_ff, long_found_in;
   logic [IW-1:0] long_id_ff, long_id_in;
   logic          pnew_found_ff, pnew_found_in;
   logic [IW-1:0] pnew_id_ff, pnew_id_in;
   logic [15:0]   pnew_age_ff, pnew_age_in;
   logic          pp_found_ff, pp_found_in;
   logic [IW-1:0] pp_id_ff, pp_id_in;
   logic [SW-1:0] pp_rem_ff, pp_rem_in;
   logic          rn_found_ff, rn_found_in;
   logic [IW-1:0] rn_id_ff, rn_id_in;
   logic [15:0]   rn_age_ff, rn_age_in;
   logic          rp_found_ff, rp_found_in;
   logic [IW-1:0] rp_id_ff, rp_id_in;
   logic [SW-1:0] rp_rem_ff, rp_rem_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [31:0]   rsp_slot_ff, rsp_slot_in;
   logic          rsp_busy_ff, rsp_busy_in;
   logic [IW-1:0] rsp_id_ff, rsp_id_in;
   logic          rsp_empty_ff, rsp_empty_in;

   // RAM port signals.
   logic          ram_we;
   logic [IW-1:0] ram_wa;
   entry_type     ram_wd;
   logic          ram_re;
   logic [IW-1:0] ram_ra;
   logic [EW-1:0] ram_rd_raw;
   entry_type     rd_entry;
   tag_type       rd_tag;

   // Shared decode.
   logic [31:0]   req_id_wide;
   logic [IW-1:0] req_id;
   logic          id_ok;
   logic          timeout;
   logic          pick_go;
   logic [31:0]   slots_wide;
   logic [SW-1:0] slots_masked;
   logic [31:0]   rem_wide;
   logic [31:0]   ran;
   logic [31:0]   allow_wide;
   logic [31:0]   run_len;
   logic [15:0]   entry_wait;
   logic [15:0]   aged;
   logic [31:0]   rsp_id_wide;

   mass_ram #(
      .WIDTH (EW),
      .DEPTH (MAX_JOBS)
   ) u_job_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wa),
      .wr_data (ram_wd),
      .rd_en   (ram_re),
      .rd_addr (ram_ra),
      .rd_data (ram_rd_raw)
   );

   // Entry read back; an entry never written is in no queue.
   assign rd_entry = entry_type'(ram_rd_raw);
   assign rd_tag   = valid_ff[rd_addr_ff] ? rd_entry.tag : TAG_NONE;

   assign req_id_wide  = 32'(req_customer_id);
   assign req_id       = req_id_wide[IW-1:0];
   assign id_ok        = req_id_wide < 32'(MAX_JOBS);
   assign timeout      = busy_flag_ff && (slot_ff == preempt_ff);
   assign pick_go      = !busy_flag_ff && (long_found_ff || pnew_found_ff || pp_found_ff ||
                                           rn_found_ff || rp_found_ff);
   assign slots_wide   = 32'(req_slots_requested);
   assign slots_masked = slots_wide[SW-1:0];
   assign rem_wide     = 32'(rd_entry.rem);
   assign ran          = slot_ff - run_start_ff;
   assign allow_wide   = 32'(allow_ff);
   assign run_len      = (allow_wide < rem_wide) ? allow_wide : rem_wide;
   assign entry_wait   = arr_cnt_ff - rd_entry.stamp;
   assign aged         = (rd_entry.age == 16'hFFFF) ? rd_entry.age : rd_entry.age + 16'd1;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (!req_func) begin
                  state_in = id_ok ? ST_ARR : ST_IDLE;
               end else begin
                  state_in = timeout ? ST_RET : ST_SCAN;
               end
            end
         end
         ST_ARR:  state_in = ST_IDLE;
         ST_RET:  state_in = ST_SCAN;
         ST_SCAN: begin
            if (cnt_ff == CW'(MAX_JOBS)) begin
               state_in = ST_PICK;
            end
         end
         ST_PICK: state_in = pick_go ? ST_DISP : ST_IDLE;
         ST_DISP: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath and RAM control.
   always_comb begin
      allow_in       = allow_ff;
      thresh_in      = thresh_ff;
      cnt_in         = cnt_ff;
      rd_addr_in     = rd_addr_ff;
      arr_regular_in = arr_regular_ff;
      arr_slots_in   = arr_slots_ff;
      run_regular_in = run_regular_ff;
      slot_in        = slot_ff;
      busy_flag_in   = busy_flag_ff;
      run_id_in      = run_id_ff;
      preempt_in     = preempt_ff;
      run_start_in   = run_start_ff;
      arr_cnt_in     = arr_cnt_ff;
      valid_in       = valid_ff;
      any_in         = any_ff;
      long_found_in  = long_found_ff;
      long_id_in     = long_id_ff;
      pnew_found_in  = pnew_found_ff;
      pnew_id_in     = pnew_id_ff;
      pnew_age_in    = pnew_age_ff;
      pp_found_in    = pp_found_ff;
      pp_id_in       = pp_id_ff;
      pp_rem_in      = pp_rem_ff;
      rn_found_in    = rn_found_ff;
      rn_id_in       = rn_id_ff;
      rn_age_in      = rn_age_ff;
      rp_found_in    = rp_found_ff;
      rp_id_in       = rp_id_ff;
      rp_rem_in      = rp_rem_ff;
      rsp_valid_in   = 1'b0;
      rsp_slot_in    = rsp_slot_ff;
      rsp_busy_in    = rsp_busy_ff;
      rsp_id_in      = rsp_id_ff;
      rsp_empty_in   = rsp_empty_ff;
      ram_we         = 1'b0;
      ram_wa         = rd_addr_ff;
      ram_wd         = rd_entry;
      ram_re         = 1'b0;
      ram_ra         = rd_addr_ff;

      // Register writes; a zero is stored as one.
      if (csr_wr_en) begin
         case (csr_index)
            CSR_TIME_ALLOWANCE: allow_in  = (csr_wdata == 16'd0) ? 16'd1 : csr_wdata;
            CSR_AGE_THRESHOLD:  thresh_in = (csr_wdata == 16'd0) ? 16'd1 : csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (!req_func) begin
                  // Arrival: fetch the entry to check that the id is free.
                  ram_re         = id_ok;
                  ram_ra         = req_id;
                  rd_addr_in     = req_id;
                  arr_regular_in = req_regular_class;
                  arr_slots_in   = (slots_masked == '0) ? SW'(1) : slots_masked;
               end else begin
                  // Tick: fetch the running job if its run has ended.
                  ram_re        = timeout;
                  ram_ra        = run_id_ff;
                  rd_addr_in    = run_id_ff;
                  cnt_in        = '0;
                  any_in        = 1'b0;
                  long_found_in = 1'b0;
                  pnew_found_in = 1'b0;
                  pp_found_in   = 1'b0;
                  rn_found_in   = 1'b0;
                  rp_found_in   = 1'b0;
               end
            end
         end

         ST_ARR: begin
            if (rd_tag == TAG_NONE) begin
               ram_we       = 1'b1;
               ram_wd.tag   = arr_regular_ff ? TAG_RNEW : TAG_PNEW;
               ram_wd.stamp = arr_cnt_ff;
               ram_wd.age   = 16'd0;
               ram_wd.rem   = arr_slots_ff;
               valid_in[rd_addr_ff] = 1'b1;
               arr_cnt_in   = arr_cnt_ff + 16'd1;
            end
         end

         ST_RET: begin
            // Retire and requeue any remainder into the played list of its class.
            ram_we = 1'b1;
            if (ran >= rem_wide) begin
               ram_wd.rem = '0;
               ram_wd.tag = TAG_NONE;
            end else begin
               ram_wd.rem = rd_entry.rem - ran[SW-1:0];
               ram_wd.tag = (rd_tag == TAG_RUN_R) ? TAG_RPLAYED : TAG_PPLAYED;
            end
            busy_flag_in = 1'b0;
            run_id_in    = '0;
         end

         ST_SCAN: begin
            // Issue the read of the next entry.
            if (cnt_ff < CW'(MAX_JOBS)) begin
               ram_re     = 1'b1;
               ram_ra     = cnt_ff[IW-1:0];
               rd_addr_in = cnt_ff[IW-1:0];
            end
            cnt_in = cnt_ff + CW'(1);
            // Judge the entry read in the previous cycle; tags are pre-aging.
            if (cnt_ff != '0) begin
               if (rd_tag != TAG_NONE) begin
                  any_in = 1'b1;
               end
               case (rd_tag)
                  TAG_LONG: begin
                     long_found_in = 1'b1;
                     long_id_in    = rd_addr_ff;
                  end
                  TAG_PNEW: begin
                     if (!pnew_found_ff || entry_wait > pnew_age_ff) begin
                        pnew_found_in = 1'b1;
                        pnew_id_in    = rd_addr_ff;
                        pnew_age_in   = entry_wait;
                     end
                  end
                  TAG_PPLAYED: begin
                     if (!pp_found_ff || rd_entry.rem < pp_rem_ff) begin
                        pp_found_in = 1'b1;
                        pp_id_in    = rd_addr_ff;
                        pp_rem_in   = rd_entry.rem;
                     end
                  end
                  TAG_RNEW: begin
                     if (!rn_found_ff || entry_wait > rn_age_ff) begin
                        rn_found_in = 1'b1;
                        rn_id_in    = rd_addr_ff;
                        rn_age_in   = entry_wait;
                     end
                     // Age the waiting regular job and promote it at threshold.
                     ram_we     = 1'b1;
                     ram_wd.age = aged;
                     ram_wd.tag = (aged >= thresh_ff) ? TAG_LONG : TAG_RNEW;
                  end
                  TAG_RPLAYED: begin
                     if (!rp_found_ff || rd_entry.rem < rp_rem_ff) begin
                        rp_found_in = 1'b1;
                        rp_id_in    = rd_addr_ff;
                        rp_rem_in   = rd_entry.rem;
                     end
                  end
                  default: ;
               endcase
            end
         end

         ST_PICK: begin
            if (pick_go) begin
               // Choose by queue order and fetch the chosen entry.
               ram_re = 1'b1;
               if (long_found_ff) begin
                  ram_ra = long_id_ff;  run_regular_in = 1'b1;
               end else if (pnew_found_ff) begin
                  ram_ra = pnew_id_ff;  run_regular_in = 1'b0;
               end else if (pp_found_ff) begin
                  ram_ra = pp_id_ff;    run_regular_in = 1'b0;
               end else if (rn_found_ff) begin
                  ram_ra = rn_id_ff;    run_regular_in = 1'b1;
               end else begin
                  ram_ra = rp_id_ff;    run_regular_in = 1'b1;
               end
               rd_addr_in = ram_ra;
            end else begin
               rsp_valid_in = 1'b1;
               rsp_slot_in  = slot_ff;
               rsp_busy_in  = busy_flag_ff;
               rsp_id_in    = busy_flag_ff ? run_id_ff : '0;
               rsp_empty_in = !busy_flag_ff && !any_ff;
               slot_in      = slot_ff + 32'd1;
            end
         end

         ST_DISP: begin
            // Start the chosen job for min(allowance, remaining) slots.
            ram_we       = 1'b1;
            ram_wd.tag   = run_regular_ff ? TAG_RUN_R : TAG_RUN_P;
            busy_flag_in = 1'b1;
            run_id_in    = rd_addr_ff;
            run_start_in = slot_ff;
            preempt_in   = slot_ff + run_len;
            rsp_valid_in = 1'b1;
            rsp_slot_in  = slot_ff;
            rsp_busy_in  = 1'b1;
            rsp_id_in    = rd_addr_ff;
            rsp_empty_in = 1'b0;
            slot_in      = slot_ff + 32'd1;
         end

         default: ;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         allow_ff     <= ALLOWANCE_RESET;
         thresh_ff    <= THRESHOLD_RESET;
         slot_ff      <= '0;
         busy_flag_ff <= 1'b0;
         run_id_ff    <= '0;
         preempt_ff   <= '0;
         run_start_ff <= '0;
         arr_cnt_ff   <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         allow_ff     <= allow_in;
         thresh_ff    <= thresh_in;
         slot_ff      <= slot_in;
         busy_flag_ff <= busy_flag_in;
         run_id_ff    <= run_id_in;
         preempt_ff   <= preempt_in;
         run_start_ff <= run_start_in;
         arr_cnt_ff   <= arr_cnt_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      rd_addr_ff     <= rd_addr_in;
      arr_regular_ff <= arr_regular_in;
      arr_slots_ff   <= arr_slots_in;
      run_regular_ff <= run_regular_in;
      any_ff         <= any_in;
      long_found_ff  <= long_found_in;
      long_id_ff     <= long_id_in;
      pnew_found_ff  <= pnew_found_in;
      pnew_id_ff     <= pnew_id_in;
      pnew_age_ff    <= pnew_age_in;
      pp_found_ff    <= pp_found_in;
      pp_id_ff       <= pp_id_in;
      pp_rem_ff      <= pp_rem_in;
      rn_found_ff    <= rn_found_in;
      rn_id_ff       <= rn_id_in;
      rn_age_ff      <= rn_age_in;
      rp_found_ff    <= rp_found_in;
      rp_id_ff       <= rp_id_in;
      rp_rem_ff      <= rp_rem_in;
      rsp_slot_ff    <= rsp_slot_in;
      rsp_busy_ff    <= rsp_busy_in;
      rsp_id_ff      <= rsp_id_in;
      rsp_empty_ff   <= rsp_empty_in;
   end

   // Outputs.
   assign rsp_id_wide          = 32'(rsp_id_ff);
   assign busy                 = (state_ff != ST_IDLE);
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_time_slot        = rsp_slot_ff;
   assign rsp_machine_busy     = rsp_busy_ff;
   assign rsp_active_customer  = rsp_id_wide[5:0];
   assign rsp_all_queues_empty = rsp_empty_ff;

   // A result follows only the decision step of a tick.
   a_rsp_after_tick: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(state_ff) == ST_PICK || $past(state_ff) == ST_DISP))
      else $error("result strobe without a finished tick");

   // An empty report never comes with a busy machine.
   a_empty_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_all_queues_empty |-> !rsp_machine_busy)
      else $error("empty report while the machine is busy");

   // The sweep counter never passes the table depth.
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> cnt_ff <= CW'(MAX_JOBS))
      else $error("sweep counter out of range");

   // Each result advances the slot clock by exactly one.
   a_slot_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_in |=> slot_ff == $past(slot_ff) + 32'd1)
      else $error("slot clock did not advance with a result");

endmodule

/* rtl/mass_ram.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ---------------------------------------------------------------------------
module mass_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* tb/sv/tb_multilevel_aging_slot_scheduler.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Testbench for the multilevel aging slot scheduler
// Drives arrival and tick items through the start/busy handshake. Register
// settings change between phases. A scoreboard predicts every slot result from
// its own model of the job table and compares each strobed result field by field.
// ---------------------------------------------------------------------------
module tb_multilevel_aging_slot_scheduler
   import mass_pkg::*;
();

   localparam int JOBS       = DEF_MAX_JOBS;
   localparam int IDLE_LIMIT = 3000;

   // One slot result as it appears on the rsp_ ports.
   typedef struct {
      logic [31:0] slot;
      logic        busy;
      logic [5:0]  cust;
      logic        empty;
   } slot_result_type;

   // Scoreboard: holds a model of the job table and the pending slot results.
   class sched_scoreboard_type;
      logic [15:0] allowance, threshold;
      logic [31:0] slot_clk, preempt_at, run_begin;
      logic        running;
      logic [5:0]  run_id;
      logic [15:0] remain [JOBS];
      logic [15:0] wait_ticks [JOBS];
      logic [15:0] stamp [JOBS];
      tag_type     tag [JOBS];
      logic [15:0] arr_cnt;
      slot_result_type pending_slots[$];
      int errors, ticks, busy_slots, promotions;

      function new();
         allowance = ALLOWANCE_RESET;
         threshold = THRESHOLD_RESET;
         slot_clk = 0; preempt_at = 0; run_begin = 0;
         running = 0; run_id = 0; arr_cnt = 0;
         for (int i = 0; i < JOBS; i++) begin
            remain[i] = 0; wait_ticks[i] = 0; stamp[i] = 0; tag[i] = TAG_NONE;
         end
         errors = 0; ticks = 0; busy_slots = 0; promotions = 0;
      endfunction

      // A zero write is stored as one.
      function void write_reg(logic [0:0] idx, logic [15:0] v);
         if (v == 0) v = 1;
         if (idx == CSR_TIME_ALLOWANCE) allowance = v;
         else threshold = v;
      endfunction

      function int pick_oldest(tag_type t);
         int best;
         logic [15:0] best_age, a;
         best = -1; best_age = 0;
         for (int i = 0; i < JOBS; i++)
            if (tag[i] == t) begin
               a = arr_cnt - stamp[i];
               if (best < 0 || a > best_age) begin
                  best = i; best_age = a;
               end
            end
         return best;
      endfunction

      function int pick_least(tag_type t);
         int best;
         best = -1;
         for (int i = 0; i < JOBS; i++)
            if (tag[i] == t && (best < 0 || remain[i] < remain[best])) best = i;
         return best;
      endfunction

      function int pick_highest(tag_type t);
         for (int i = JOBS - 1; i >= 0; i--)
            if (tag[i] == t) return i;
         return -1;
      endfunction

      function void launch(int id, tag_type run_tag);
         logic [15:0] len;
         len = (allowance < remain[id]) ? allowance : remain[id];
         tag[id] = run_tag;
         run_id = 6'(id);
         running = 1;
         run_begin = slot_clk;
         preempt_at = slot_clk + 32'(len);
      endfunction

      // Update the model for one accepted item.
      function void note_item(logic func, logic [5:0] id, logic cls, logic [15:0] slots);
         int pick;
         logic [31:0] ran;
         logic [15:0] rem;
         slot_result_type r;
         if (!func) begin
            if (tag[id] != TAG_NONE) return;
            remain[id] = (slots == 0) ? 16'd1 : slots;
            wait_ticks[id] = 0;
            stamp[id] = arr_cnt;
            arr_cnt++;
            tag[id] = cls ? TAG_RNEW : TAG_PNEW;
            return;
         end
         // Retire the running job at its timeout.
         if (running && slot_clk == preempt_at) begin
            ran = slot_clk - run_begin;
            rem = (ran >= 32'(remain[run_id])) ? 16'd0 : remain[run_id] - ran[15:0];
            remain[run_id] = rem;
            if (rem == 0) tag[run_id] = TAG_NONE;
            else tag[run_id] = (tag[run_id] == TAG_RUN_R) ? TAG_RPLAYED : TAG_PPLAYED;
            running = 0;
            run_id = 0;
         end
         // Dispatch in queue order when the machine is free.
         if (!running) begin
            pick = pick_highest(TAG_LONG);
            if (pick >= 0) launch(pick, TAG_RUN_R);
            else begin
               pick = pick_oldest(TAG_PNEW);
               if (pick >= 0) launch(pick, TAG_RUN_P);
               else begin
                  pick = pick_least(TAG_PPLAYED);
                  if (pick >= 0) launch(pick, TAG_RUN_P);
                  else begin
                     pick = pick_oldest(TAG_RNEW);
                     if (pick >= 0) launch(pick, TAG_RUN_R);
                     else begin
                        pick = pick_least(TAG_RPLAYED);
                        if (pick >= 0) launch(pick, TAG_RUN_R);
                     end
                  end
               end
            end
         end
         r.slot = slot_clk;
         r.busy = running;
         r.cust = running ? run_id : 6'd0;
         r.empty = !running;
         for (int i = 0; i < JOBS; i++)
            if (tag[i] != TAG_NONE) r.empty = 0;
         pending_slots.insert(pending_slots.size(), r);
         ticks++;
         if (running) busy_slots++;
         // Age the regular-new jobs and promote them at the threshold.
         for (int i = 0; i < JOBS; i++)
            if (tag[i] == TAG_RNEW) begin
               if (wait_ticks[i] != 16'hFFFF) wait_ticks[i]++;
               if (wait_ticks[i] >= threshold) begin
                  tag[i] = TAG_LONG;
                  promotions++;
               end
            end
         slot_clk++;
      endfunction

      task report(string what, logic [31:0] got, logic [31:0] want);
         $display("[%0t] mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
         errors++;
      endtask

      task check(slot_result_type got);
         slot_result_type want;
         if (pending_slots.size() == 0) begin
            report("unrequested result slot", got.slot, 32'd0);
            return;
         end
         want = pending_slots[0];
         pending_slots.delete(0);
         if (got.slot != want.slot) report("time_slot", got.slot, want.slot);
         if (got.busy != want.busy) report("machine_busy", 32'(got.busy), 32'(want.busy));
         if (got.cust != want.cust) report("active_customer", 32'(got.cust), 32'(want.cust));
         if (got.empty != want.empty)
            report("all_queues_empty", 32'(got.empty), 32'(want.empty));
      endtask
   endclass

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic        req_func;
   logic [5:0]  req_customer_id;
   logic        req_regular_class;
   logic [15:0] req_slots_requested;
   logic        csr_wr_en;
   logic [0:0]  csr_index;
   logic [15:0] csr_wdata;
   logic        rsp_valid;
   logic [31:0] rsp_time_slot;
   logic        rsp_machine_busy;
   logic [5:0]  rsp_active_customer;
   logic        rsp_all_queues_empty;

   sched_scoreboard_type sb;
   int items_sent;
   int idle_cycles;

   multilevel_aging_slot_scheduler u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_func(req_func), .req_customer_id(req_customer_id),
      .req_regular_class(req_regular_class), .req_slots_requested(req_slots_requested),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .rsp_valid(rsp_valid), .rsp_time_slot(rsp_time_slot),
      .rsp_machine_busy(rsp_machine_busy), .rsp_active_customer(rsp_active_customer),
      .rsp_all_queues_empty(rsp_all_queues_empty)
   );

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   // Result monitor and idle watchdog.
   always @(posedge clock) begin
      slot_result_type got;
      if (!reset) begin
         if (rsp_valid) begin
            got.slot = rsp_time_slot;
            got.busy = rsp_machine_busy;
            got.cust = rsp_active_customer;
            got.empty = rsp_all_queues_empty;
            sb.check(got);
         end
         if (rsp_valid || (start && !busy)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no activity for %0d cycles", IDLE_LIMIT);
            $display("simulation failed");
            $finish;
         end
      end
   end

   // Present one item after an optional gap and wait until it is taken.
   task send_item(logic func, logic [5:0] id, logic cls, logic [15:0] slots, int gap);
      if (gap > 0) begin
         start <= 0;
         repeat (gap) @(posedge clock);
      end
      start <= 1;
      req_func <= func;
      req_customer_id <= id;
      req_regular_class <= cls;
      req_slots_requested <= slots;
      do @(posedge clock); while (busy);
      sb.note_item(func, id, cls, slots);
      items_sent++;
   endtask

   // Stop sending and wait until the block is idle with nothing pending.
   task drain();
      start <= 0;
      repeat (4) @(posedge clock);
      while (busy || sb.pending_slots.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task write_csr(logic [0:0] idx, logic [15:0] v);
      csr_wr_en <= 1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      csr_wr_en <= 0;
      sb.write_reg(idx, v);
   endtask

   function int pick_gap(bit calm);
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 75) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Random phase: mostly ticks, plus arrivals of mostly free ids with small sizes.
   task random_phase(int count, bit calm);
      logic [5:0]  id;
      logic [15:0] slots;
      int r;
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(0, 99);
         if (r < 55) begin
            send_item(1'b1, 6'($urandom), 1'($urandom), 16'($urandom), pick_gap(calm));
         end else begin
            id = 6'($urandom);
            // Most arrivals look for a free id; the rest may hit a busy one.
            if (r < 92)
               for (int k = 0; k < JOBS && sb.tag[id] != TAG_NONE; k++) id++;
            r = $urandom_range(0, 99);
            if (r < 70) slots = 16'($urandom_range(1, 12));
            else if (r < 95) slots = 16'($urandom_range(0, 300));
            else slots = 16'($urandom_range(0, 65535));
            send_item(1'b0, id, 1'($urandom), slots, pick_gap(calm));
         end
      end
      drain();
   endtask

   initial begin
      sb = new();
      items_sent = 0;
      idle_cycles = 0;
      reset = 1;
      start = 0;
      req_func = 0;
      req_customer_id = 0;
      req_regular_class = 0;
      req_slots_requested = 0;
      csr_wr_en = 0;
      csr_index = CSR_TIME_ALLOWANCE;
      csr_wdata = 0;
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed part: short allowance and threshold so every queue is used.
      write_csr(CSR_TIME_ALLOWANCE, 16'd3);
      write_csr(CSR_AGE_THRESHOLD, 16'd2);
      send_item(1'b1, 6'd0, 1'b0, 16'd0, 0);         // tick with every queue empty
      send_item(1'b0, 6'd0, 1'b0, 16'd0, 0);         // zero slots taken as one
      send_item(1'b0, 6'd63, 1'b0, 16'd5, 0);
      send_item(1'b0, 6'd1, 1'b1, 16'd2, 0);
      send_item(1'b0, 6'd42, 1'b1, 16'hFFFF, 0);     // longest job
      send_item(1'b0, 6'd0, 1'b1, 16'd9, 0);         // id already queued, ignored
      send_item(1'b0, 6'd7, 1'b1, 16'd4, 0);
      for (int n = 0; n < 16; n++) send_item(1'b1, 6'h3F, 1'b1, 16'hFFFF, 0);
      drain();

      // Settings sweep: extremes, zero writes, random values, then defaults.
      write_csr(CSR_TIME_ALLOWANCE, 16'd1);
      write_csr(CSR_AGE_THRESHOLD, 16'd1);
      random_phase(190, 0);
      write_csr(CSR_TIME_ALLOWANCE, 16'hFFFF);
      write_csr(CSR_AGE_THRESHOLD, 16'hFFFF);
      random_phase(190, 1);
      write_csr(CSR_TIME_ALLOWANCE, 16'd0);
      write_csr(CSR_AGE_THRESHOLD, 16'd0);
      random_phase(190, 0);
      for (int p = 0; p < 3; p++) begin
         write_csr(CSR_TIME_ALLOWANCE, 16'($urandom_range(0, 65535)));
         write_csr(CSR_AGE_THRESHOLD, 16'($urandom_range(0, 65535)));
         write_csr(CSR_TIME_ALLOWANCE, 16'($urandom_range(1, 10)));
         write_csr(CSR_AGE_THRESHOLD, 16'($urandom_range(1, 40)));
         random_phase(170, p[0]);
      end
      write_csr(CSR_TIME_ALLOWANCE, ALLOWANCE_RESET);
      write_csr(CSR_AGE_THRESHOLD, THRESHOLD_RESET);
      random_phase(260, 0);

      repeat (80) @(posedge clock);
      if (sb.pending_slots.size() != 0)
         sb.report("results never seen", 32'(sb.pending_slots.size()), 32'd0);
      $display("Covered %0d items, %0d ticks, %0d busy slots, %0d promotions to long-wait.",
               items_sent, sb.ticks, sb.busy_slots, sb.promotions);
      if (sb.errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("%0d mismatches", sb.errors);
         $display("simulation failed");
      end
      $finish;
   end

endmodule
